// ===== hw/rtl/mtp_pkg.sv =====
`default_nettype none

package mtp_pkg;

  localparam int unsigned TableDepth = 624;
  localparam int unsigned IdxW       = 10;
  localparam int unsigned DataW      = 64;
  localparam int unsigned SeedW      = 31;

  // Active lengths and twist offsets of the two word sizes.
  localparam logic [IdxW-1:0] Len32 = 10'd624;
  localparam logic [IdxW-1:0] Len64 = 10'd312;
  localparam logic [IdxW-1:0] Off32 = 10'd397;
  localparam logic [IdxW-1:0] Off64 = 10'd156;

  localparam logic [16:0]      FillMult  = 17'd69069;
  localparam logic [DataW-1:0] Matrix32  = 64'd2573724191;
  localparam logic [DataW-1:0] Matrix64  = 64'hB5026F5AA96619E9;
  localparam logic [DataW-1:0] Upper32   = 64'h0000_0000_8000_0000;
  localparam logic [DataW-1:0] Upper64   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [DataW-1:0] LowerMask = 64'h0000_0000_7FFF_FFFF;

  localparam logic OpGenerate = 1'b0;
  localparam logic OpReseed   = 1'b1;

  function automatic logic [DataW-1:0] temper32(input logic [DataW-1:0] w);
    logic [31:0] y;
    y = w[31:0];
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return {32'b0, y};
  endfunction

  function automatic logic [DataW-1:0] temper64(input logic [DataW-1:0] w);
    logic [DataW-1:0] y;
    y = w;
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'hD66B5EF5B4DA0000);
    y = y ^ ((y << 37) & 64'hFDED6BE000000000);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mtp_intf.sv =====
`default_nettype none

interface mtp_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [mtp_pkg::DataW-1:0]     seed_value;

  modport source (output valid, output op, output seed_value, input ready);
  modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface mtp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mtp_pkg::DataW-1:0]     random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mersenne_twister_prng.sv =====
// Mersenne Twister generator, MT19937 (word_mode 0, 624 words) or MT19937-64
// (word_mode 1, 312 words), with its state in one single-port table of 624 x 64
// bits. A generate transaction reads the table and then tempers the word into
// the output register. When the read index has reached the active length,
// that generate first runs a twist, in which each new word needs two reads and
// one write on the single table port, and then reads the first new word before
// tempering it. A reseed transaction refills all 624 words, one per cycle, and
// forces a twist before the next output. After reset the same fill pass runs
// with seed 0, during which no transaction is accepted; word_mode may be
// written at any time the block is idle.
`default_nettype none

module mersenne_twister_prng (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_wdata_i,
  mtp_req_if.sink          req_i,
  mtp_rsp_if.source        rsp_o
);

  typedef enum logic [2:0] {
    StFill,
    StIdle,
    StTwStart,
    StTwA,
    StTwB,
    StTwC,
    StGenRd,
    StTemper
  } state_e;

  localparam int unsigned IdxW  = mtp_pkg::IdxW;
  localparam int unsigned DataW = mtp_pkg::DataW;
  localparam logic [IdxW-1:0] LastEntry = IdxW'(mtp_pkg::TableDepth - 1);

  state_e                  state_q;
  logic                    word_mode_q;
  logic [IdxW-1:0]         read_index_q;
  logic [IdxW-1:0]         fill_idx_q;
  logic [mtp_pkg::SeedW-1:0] fill_word_q;
  logic [IdxW-1:0]         k_q;
  logic [DataW-1:0]        cur_q;
  logic [DataW-1:0]        nxt_q;
  logic                    out_valid_q;
  logic [DataW-1:0]        random_value_q;

  logic [DataW-1:0]        table_q [mtp_pkg::TableDepth];
  logic [DataW-1:0]        rdata_q;

  logic                    mem_we;
  logic [IdxW-1:0]         mem_addr;
  logic [DataW-1:0]        mem_wdata;

  logic [DataW-1:0]        rword;
  logic [IdxW-1:0]         n_len;
  logic [IdxW-1:0]         m_off;
  logic [IdxW-1:0]         kp1;
  logic [IdxW:0]           km_sum;
  logic [IdxW-1:0]         km;
  logic [DataW-1:0]        up_mask;
  logic [DataW-1:0]        matrix;
  logic [DataW-1:0]        twist_y;
  logic [DataW-1:0]        twist_word;
  logic [47:0]             fill_prod;
  logic                    in_ready;

  // In 32-bit mode every table word is seen through its low half only.
  assign rword   = word_mode_q ? rdata_q : {32'b0, rdata_q[31:0]};
  assign n_len   = word_mode_q ? mtp_pkg::Len64 : mtp_pkg::Len32;
  assign m_off   = word_mode_q ? mtp_pkg::Off64 : mtp_pkg::Off32;
  assign up_mask = word_mode_q ? mtp_pkg::Upper64 : mtp_pkg::Upper32;
  assign matrix  = word_mode_q ? mtp_pkg::Matrix64 : mtp_pkg::Matrix32;

  assign kp1    = (k_q == n_len - IdxW'(1)) ? '0 : k_q + IdxW'(1);
  assign km_sum = {1'b0, k_q} + {1'b0, m_off};
  assign km     = (km_sum >= {1'b0, n_len}) ? km_sum[IdxW-1:0] - n_len : km_sum[IdxW-1:0];

  assign twist_y    = (cur_q & up_mask) | (nxt_q & mtp_pkg::LowerMask);
  assign twist_word = rword ^ (twist_y >> 1) ^ (twist_y[0] ? matrix : '0);

  assign fill_prod = {17'b0, fill_word_q} * {31'b0, mtp_pkg::FillMult};

  assign in_ready    = (state_q == StIdle) && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.random_value = random_value_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = read_index_q;
    mem_wdata = twist_word;
    case (state_q)
      StFill: begin
        mem_we    = 1'b1;
        mem_addr  = fill_idx_q;
        mem_wdata = {33'b0, fill_word_q};
      end
      StTwStart: mem_addr = '0;
      StTwA:     mem_addr = kp1;
      StTwB:     mem_addr = km;
      StTwC: begin
        mem_we   = 1'b1;
        mem_addr = k_q;
      end
      default:   mem_addr = read_index_q;
    endcase
  end

  // Single-port table: one read or one write per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_q[mem_addr] <= mem_wdata;
    end else begin
      rdata_q <= table_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StFill;
      word_mode_q    <= 1'b0;
      read_index_q   <= mtp_pkg::Len32 + IdxW'(1);
      fill_idx_q     <= '0;
      fill_word_q    <= '0;
      k_q            <= '0;
      cur_q          <= '0;
      nxt_q          <= '0;
      out_valid_q    <= 1'b0;
      random_value_q <= '0;
    end else begin
      if (cfg_we_i) begin
        word_mode_q <= cfg_wdata_i[0];
      end
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StFill: begin
          fill_word_q <= fill_prod[mtp_pkg::SeedW-1:0];
          if (fill_idx_q == LastEntry) begin
            state_q <= StIdle;
          end else begin
            fill_idx_q <= fill_idx_q + IdxW'(1);
          end
        end
        StIdle: begin
          if (req_i.valid && in_ready) begin
            if (req_i.op == mtp_pkg::OpReseed) begin
              fill_word_q  <= req_i.seed_value[mtp_pkg::SeedW-1:0];
              fill_idx_q   <= '0;
              read_index_q <= n_len + IdxW'(1);
              state_q      <= StFill;
            end else if (read_index_q >= n_len) begin
              k_q     <= '0;
              state_q <= StTwStart;
            end else begin
              state_q <= StTemper;
            end
          end
        end
        StTwStart: state_q <= StTwA;
        StTwA: begin
          // On the first step the data of word 0 arrives here.
          if (k_q == '0) begin
            cur_q <= rword;
          end
          state_q <= StTwB;
        end
        StTwB: begin
          nxt_q   <= rword;
          state_q <= StTwC;
        end
        StTwC: begin
          cur_q <= nxt_q;
          if (k_q == n_len - IdxW'(1)) begin
            read_index_q <= '0;
            state_q      <= StGenRd;
          end else begin
            k_q     <= k_q + IdxW'(1);
            state_q <= StTwA;
          end
        end
        StGenRd: state_q <= StTemper;
        StTemper: begin
          random_value_q <= word_mode_q ? mtp_pkg::temper64(rword)
                                        : mtp_pkg::temper32(rword);
          out_valid_q    <= 1'b1;
          read_index_q   <= read_index_q + IdxW'(1);
          state_q        <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/mtp_checker.sv =====
module mtp_checker
  import mtp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_wdata_i,
  mtp_req_if               req_i,
  mtp_rsp_if               rsp_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  logic [DataW-1:0] gen_table [TableDepth];
  logic [IdxW-1:0]  gen_index;
  logic             gen_wide;
  logic [DataW-1:0] expected_words [$];
  logic [DataW-1:0] want_word;

  function automatic int unsigned active_len();
    return gen_wide ? int'(Len64) : int'(Len32);
  endfunction

  // In 32-bit mode only the low half of a stored word is visible.
  function automatic logic [DataW-1:0] fetch_word(input int unsigned i);
    logic [DataW-1:0] v;
    v = gen_table[i % TableDepth];
    return gen_wide ? v : {32'b0, v[31:0]};
  endfunction

  function automatic void seed_table(input logic [DataW-1:0] seed);
    logic [DataW-1:0] prod;
    gen_table[0] = seed & LowerMask;
    for (int unsigned i = 1; i < TableDepth; i++) begin
      prod = gen_table[i-1] * {47'b0, FillMult};
      gen_table[i] = prod & LowerMask;
    end
    gen_index = IdxW'(active_len() + 1);
  endfunction

  // The twist works in place, so later words see the ones already rewritten.
  function automatic void twist_table();
    int unsigned      n;
    int unsigned      m;
    logic [DataW-1:0] a;
    logic [DataW-1:0] up;
    logic [DataW-1:0] y;
    n  = active_len();
    m  = gen_wide ? int'(Off64) : int'(Off32);
    a  = gen_wide ? Matrix64 : Matrix32;
    up = gen_wide ? Upper64 : Upper32;
    for (int unsigned k = 0; k < n; k++) begin
      y = (fetch_word(k) & up) | (fetch_word((k + 1) % n) & LowerMask);
      gen_table[k] = fetch_word((k + m) % n) ^ (y >> 1) ^ (y[0] ? a : '0);
    end
    gen_index = '0;
  endfunction

  function automatic logic [DataW-1:0] temper_word(input logic [DataW-1:0] w);
    logic [DataW-1:0] y;
    logic [31:0]      t;
    if (gen_wide) begin
      y = w;
      y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
      y = y ^ ((y << 17) & 64'hD66B_5EF5_B4DA_0000);
      y = y ^ ((y << 37) & 64'hFDED_6BE0_0000_0000);
      y = y ^ (y >> 43);
      return y;
    end
    t = w[31:0];
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & 32'h9D2C_5680);
    t = t ^ ((t << 15) & 32'hEFC6_0000);
    t = t ^ (t >> 18);
    return {32'b0, t};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_wide = 1'b0;
      seed_table('0);
      expected_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        gen_wide = cfg_wdata_i[0];
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.op == OpReseed) begin
          seed_table(req_i.seed_value);
        end else begin
          if (gen_index >= IdxW'(active_len())) begin
            twist_table();
          end
          expected_words.push_back(temper_word(fetch_word(gen_index)));
          gen_index = gen_index + IdxW'(1);
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: response transaction with nothing expected, got %h",
                   $time, rsp_i.random_value);
          fail_count_o++;
        end else begin
          want_word = expected_words.pop_front();
          if (rsp_i.random_value !== want_word) begin
            $display("%0t: random_value mismatch, expected %h, got %h",
                     $time, want_word, rsp_i.random_value);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import mtp_pkg::*;

  localparam int unsigned CycleLimit  = 4_000_000;
  // A reseed gives no response but keeps the table busy for a full fill pass.
  localparam int unsigned DrainCycles = 700;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_wdata;
  bit          quiet;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count;

  mtp_req_if req_ch ();
  mtp_rsp_if rsp_ch ();

  mersenne_twister_prng u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  mtp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sends one request transaction, sometimes after a burst of idle cycles.
  task automatic send_item(input logic item_op, input logic [DataW-1:0] item_seed);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid      <= 1'b0;
      req_ch.op         <= 1'($urandom);
      req_ch.seed_value <= {$urandom, $urandom};
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= item_op;
    req_ch.seed_value <= item_seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Waits until every response has come and any fill pass has finished.
  task automatic drain_block();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned phase_items [6] = '{50, 60, 330, 40, 30, 40};
    bit          phase_wide  [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    bit          reseed;
    req_ch.valid      = 1'b0;
    req_ch.op         = OpGenerate;
    req_ch.seed_value = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    rst_n             = 1'b0;
    quiet             = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The fill pass after reset holds ready low.
    while (!req_ch.ready) @(posedge clk);
    write_mode(1'b0);

    // The table after reset holds only zeros, and so does its twist.
    send_item(OpGenerate, '0);
    send_item(OpGenerate, '1);
    // Only the low 31 bits of a seed are used.
    send_item(OpReseed, '1);
    repeat (3) send_item(OpGenerate, '0);
    send_item(OpReseed, 64'h0000_0000_8000_0000);
    send_item(OpGenerate, '0);
    send_item(OpReseed, 64'h1);
    repeat (2) send_item(OpGenerate, '1);
    // A mode change keeps both the table and the read index.
    drain_block();
    write_mode(1'b1);
    repeat (3) send_item(OpGenerate, '0);
    send_item(OpReseed, '1);
    repeat (3) send_item(OpGenerate, '0);
    send_item(OpReseed, '0);
    send_item(OpGenerate, '0);
    drain_block();
    write_mode(1'b0);
    repeat (2) send_item(OpGenerate, '0);

    for (int p = 0; p < 6; p++) begin
      drain_block();
      write_mode(phase_wide[p]);
      quiet = (p == 5);
      for (int unsigned i = 0; i < phase_items[p]; i++) begin
        // The long phase rarely reseeds, so it usually runs through the end of the table.
        if (p == 2) begin
          reseed = ($urandom_range(0, 399) == 0);
        end else begin
          reseed = ($urandom_range(0, 9) == 0);
        end
        send_item(reseed ? OpReseed : OpGenerate, {$urandom, $urandom});
      end
    end

    drain_block();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        hold = $urandom_range(1, 16);
      end else begin
        rsp_ch.ready <= 1'b1;
        hold = $urandom_range(1, 20);
      end
      repeat (hold) @(posedge clk);
    end
  end

endmodule
